/* rtl/stks_pkg.sv */
`timescale 1ns / 1ps

package stks_pkg;

    localparam int SCORE_W        = 32;
    localparam int LABEL_OUT_W    = 16;
    localparam int RANK_W         = 3;
    localparam int CFG_W          = 4;
    localparam int DEFAULT_COUNT  = 5;
    localparam int K_MAX_DEF      = 8;
    localparam int MAX_LABELS_DEF = 65536;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      last_in_column;
    } in_t;

    typedef struct packed {
        logic [RANK_W-1:0]         rank;
        logic [LABEL_OUT_W-1:0]    label_index;
        logic signed [SCORE_W-1:0] best_score;
        logic                      last_of_run;
    } out_t;

    // Commands from the controller to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the accepted score
        logic drain;  // shift the chain one place toward the head
    } ctrl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

endpackage

/* rtl/stks_cell.sv */
`timescale 1ns / 1ps

module stks_cell #(
    parameter int LABEL_W = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  stks_pkg::ctrl_t                    cmd,
    input  logic                               enable,
    input  logic                               is_tail,
    input  logic signed [stks_pkg::SCORE_W-1:0] new_score,
    input  logic [LABEL_W-1:0]                 new_label,
    input  logic                               prev_hit,
    input  logic                               prev_valid,
    input  logic signed [stks_pkg::SCORE_W-1:0] prev_score,
    input  logic [LABEL_W-1:0]                 prev_label,
    input  logic                               next_valid,
    input  logic signed [stks_pkg::SCORE_W-1:0] next_score,
    input  logic [LABEL_W-1:0]                 next_label,
    output logic                               hit,
    output logic                               valid,
    output logic signed [stks_pkg::SCORE_W-1:0] score,
    output logic [LABEL_W-1:0]                 label
);

    logic                                valid_reg;
    logic                                valid_next;
    logic signed [stks_pkg::SCORE_W-1:0] score_reg;
    logic signed [stks_pkg::SCORE_W-1:0] score_next;
    logic [LABEL_W-1:0]                  label_reg;
    logic [LABEL_W-1:0]                  label_next;
    logic                                below_new;
    logic                                new_below;

    assign below_new = score_reg < new_score;
    assign new_below = new_score < score_reg;

    // The tail slot of a full list also takes a score equal to the one it holds.
    assign hit = enable && (!valid_reg || below_new || (is_tail && !new_below));

    always_comb begin
        valid_next = valid_reg;
        score_next = score_reg;
        label_next = label_reg;
        if (cmd.load) begin
            if (!enable) begin
                valid_next = 1'b0;
            end else if (prev_hit) begin
                valid_next = prev_valid;
                score_next = prev_score;
                label_next = prev_label;
            end else if (hit) begin
                valid_next = 1'b1;
                score_next = new_score;
                label_next = new_label;
            end
        end else if (cmd.drain) begin
            valid_next = next_valid;
            score_next = next_score;
            label_next = next_label;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        score_reg <= score_next;
        label_reg <= label_next;
    end

    assign valid = valid_reg;
    assign score = score_reg;
    assign label = label_reg;

endmodule

/* rtl/stks_ctrl.sv */
`timescale 1ns / 1ps

module stks_ctrl #(
    parameter int MAX_LABELS = stks_pkg::MAX_LABELS_DEF,
    parameter int LABEL_W    = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_last,
    input  logic                        m_ready,
    input  logic                        head_last,
    output logic                        s_ready,
    output logic                        m_valid,
    output stks_pkg::ctrl_t             cmd,
    output logic [LABEL_W-1:0]          label,
    output logic [stks_pkg::RANK_W-1:0] rank
);

    localparam logic [LABEL_W-1:0] LABEL_TOP = LABEL_W'(MAX_LABELS - 1);

    stks_pkg::state_t            state_reg;
    stks_pkg::state_t            state_next;
    logic [LABEL_W-1:0]          count_reg;
    logic [LABEL_W-1:0]          count_next;
    logic [stks_pkg::RANK_W-1:0] rank_reg;
    logic [stks_pkg::RANK_W-1:0] rank_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stks_pkg::ST_COLLECT: begin
                if (s_valid && s_last) begin
                    state_next = stks_pkg::ST_EMIT;
                end
            end
            stks_pkg::ST_EMIT: begin
                if (m_ready && head_last) begin
                    state_next = stks_pkg::ST_COLLECT;
                end
            end
            default: state_next = stks_pkg::ST_COLLECT;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        cmd.load  = 1'b0;
        cmd.drain = 1'b0;
        case (state_reg)
            stks_pkg::ST_COLLECT: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            stks_pkg::ST_EMIT: begin
                m_valid   = 1'b1;
                cmd.drain = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // The row counter saturates, so every later score shares the top label.
    always_comb begin
        count_next = count_reg;
        if (cmd.load) begin
            if (s_last) begin
                count_next = '0;
            end else if (count_reg != LABEL_TOP) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_comb begin
        rank_next = rank_reg;
        if (cmd.drain) begin
            rank_next = head_last ? '0 : rank_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stks_pkg::ST_COLLECT;
            count_reg <= '0;
            rank_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    assign label = count_reg;
    assign rank  = rank_reg;

endmodule

/* rtl/streaming_top_k_selector.sv */
`timescale 1ns / 1ps
// Channel   Direction  Signals                          Carries
// s_        in         s_valid, s_ready, s_data         one score and end-of-column flag
// m_        out        m_valid, m_ready, m_data         one ranked entry per transfer
// cfg_      in         cfg_valid, cfg_ready, cfg_wdata  top_count register
//
// One score is inserted per cycle by the compare-and-shift cell chain while it
// collects. After the last score of a column the chain drains toward the head,
// one entry per cycle while m_ready is high; the chain keeps the k best scores, where
// k is the kept count (five for a zero top_count, never more than K_MAX); no score
// is accepted during that drain. A stalled m_ready holds the current entry.
// Reset clears the slot valid bits, the row counter and sets top_count to five.

module streaming_top_k_selector #(
    parameter int K_MAX      = stks_pkg::K_MAX_DEF,
    parameter int MAX_LABELS = stks_pkg::MAX_LABELS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  stks_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output stks_pkg::out_t             m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [stks_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int LABEL_W = ($clog2(MAX_LABELS) > 0) ? $clog2(MAX_LABELS) : 1;
    localparam int KW      = ($clog2(K_MAX + 1) > stks_pkg::CFG_W) ?
                             $clog2(K_MAX + 1) : stks_pkg::CFG_W;

    logic [stks_pkg::CFG_W-1:0]           top_count_reg;
    logic [KW-1:0]                        k_sel;
    logic [KW-1:0]                        k_eff;
    stks_pkg::ctrl_t                      cmd;
    logic [LABEL_W-1:0]                   new_label;
    logic [stks_pkg::RANK_W-1:0]          rank;
    logic                                 head_last;
    logic [K_MAX-1:0]                     valid_vec;

    // Chain position j holds cell j-1; the two ends are tied off.
    logic                                 hit_a   [0:K_MAX+1];
    logic                                 valid_a [0:K_MAX+1];
    logic signed [stks_pkg::SCORE_W-1:0]  score_a [0:K_MAX+1];
    logic [LABEL_W-1:0]                   label_a [0:K_MAX+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg <= stks_pkg::CFG_W'(stks_pkg::DEFAULT_COUNT);
        end else if (cfg_valid && cfg_ready) begin
            top_count_reg <= cfg_wdata;
        end
    end

    assign k_sel = (top_count_reg == '0) ? KW'(stks_pkg::DEFAULT_COUNT) : KW'(top_count_reg);
    assign k_eff = (k_sel > KW'(K_MAX)) ? KW'(K_MAX) : k_sel;

    assign hit_a[0]         = 1'b0;
    assign valid_a[0]       = 1'b0;
    assign score_a[0]       = '0;
    assign label_a[0]       = '0;
    assign hit_a[K_MAX+1]   = 1'b0;
    assign valid_a[K_MAX+1] = 1'b0;
    assign score_a[K_MAX+1] = '0;
    assign label_a[K_MAX+1] = '0;

    genvar i;
    generate
        for (i = 0; i < K_MAX; i++) begin : g_cell
            stks_cell #(
                .LABEL_W (LABEL_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .enable     (KW'(i) < k_eff),
                .is_tail    (KW'(i) == k_eff - 1'b1),
                .new_score  (s_data.score),
                .new_label  (new_label),
                .prev_hit   (hit_a[i]),
                .prev_valid (valid_a[i]),
                .prev_score (score_a[i]),
                .prev_label (label_a[i]),
                .next_valid (valid_a[i+2]),
                .next_score (score_a[i+2]),
                .next_label (label_a[i+2]),
                .hit        (hit_a[i+1]),
                .valid      (valid_a[i+1]),
                .score      (score_a[i+1]),
                .label      (label_a[i+1])
            );
            assign valid_vec[i] = valid_a[i+1];
        end
    endgenerate

    assign head_last = !valid_a[2];

    stks_ctrl #(
        .MAX_LABELS (MAX_LABELS),
        .LABEL_W    (LABEL_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_last    (s_data.last_in_column),
        .m_ready   (m_ready),
        .head_last (head_last),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .cmd       (cmd),
        .label     (new_label),
        .rank      (rank)
    );

    assign m_data.rank        = rank;
    assign m_data.label_index = stks_pkg::LABEL_OUT_W'(label_a[1]);
    assign m_data.best_score  = score_a[1];
    assign m_data.last_of_run = head_last;

    // The two channels are never open at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels open together");

    // The end of a column always leads to at least one result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_in_column) |=> m_valid)
        else $error("column end without a result");

    // Valid slots always form a prefix of the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("slot valid bits are not a prefix");

    // A result on the port always comes from a filled head slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> valid_vec[0])
        else $error("result offered from an empty head slot");

endmodule
